[rtl/assert_macros.svh]
// Assertion macros used by the allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication.
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

[rtl/ffha_pkg.sv]
// Types, constants and command codes shared by the allocator modules.
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int HEAP_BYTES   = 1024 * 1024;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_BLOCKS   = 64;
  localparam int ALIGN        = 8;

  localparam int OFS_W  = 20;
  localparam int SIZE_W = 32;
  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int NEED_W = OFS_W + 1;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
    logic             free;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    start: '0,
    size:  OFS_W'(HEAP_BYTES - HEADER_BYTES),
    free:  1'b1
  };

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_CALLOC  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FAIL   = 2'd1,
    ST_BADPTR = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_KCLR, OP_RD, OP_NEXTK, OP_FOUND,
    OP_GRANT_WHOLE, OP_SH_RD, OP_SH_WR, OP_WR_NEW, OP_WR_OLD, OP_RD_NEXT,
    OP_MERGE, OP_UP_RD, OP_UP_WR, OP_SET_STATUS, OP_RES_PTR, OP_SAVE_OLD,
    OP_RES_COPY, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    ptr_zero;
    logic    size_zero;
    logic    alloc_bad;
    logic    calloc_ovf;
    logic    k_end;
    logic    fit;
    logic    split_ok;
    logic    match;
    logic    rd_free;
    logic    j_at_split;
    logic    has_next;
    logic    j_lt_cnt;
    logic    old_fits;
  } stat_t;

endpackage

[rtl/ffha_dp.sv]
// Allocator datapath: block table memory, scan indexes, arithmetic and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffha_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ffha_pkg::cmd_t                cmd,
  output ffha_pkg::stat_t               st,
  input  logic [1:0]                    action,
  input  logic [ffha_pkg::SIZE_W-1:0]   request_size,
  input  logic [ffha_pkg::SIZE_W-1:0]   element_count,
  input  logic [ffha_pkg::OFS_W-1:0]    pointer_offset,
  output logic                          done,
  output logic [ffha_pkg::OFS_W-1:0]    result_offset,
  output logic [1:0]                    status,
  output logic [ffha_pkg::OFS_W-1:0]    copy_length,
  output logic                          zero_fill
);

  localparam int HDR_W = ffha_pkg::OFS_W + 2;

  ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t rd_q, fent, pent;
  logic             init0;

  ffha_pkg::action_t                  act_q;
  logic [ffha_pkg::SIZE_W-1:0]        size_q, count_q;
  logic [ffha_pkg::OFS_W-1:0]         ptr_q, old_size;
  logic [2*ffha_pkg::SIZE_W-1:0]      prod;
  logic [ffha_pkg::NEED_W-1:0]        need;
  logic [ffha_pkg::CNT_W-1:0]         cnt, k, j;
  logic [ffha_pkg::IDX_W-1:0]         fidx;
  logic [1:0]                         rmv;

  logic [2*ffha_pkg::SIZE_W-1:0]      alloc_src;
  logic [ffha_pkg::NEED_W-1:0]        need_calc;
  logic                               nm, pm;
  logic [ffha_pkg::IDX_W-1:0]         p_idx;
  logic [1:0]                         rmv_calc;
  logic [ffha_pkg::CNT_W-1:0]         cnt_less;
  ffha_pkg::entry_t                   merged, split_e;
  logic                               rd_en, wr_en;
  logic [ffha_pkg::IDX_W-1:0]         rd_addr, wr_addr;
  ffha_pkg::entry_t                   wr_data;

  always_comb begin
    alloc_src = (act_q == ffha_pkg::ACT_CALLOC) ? prod
                                                : {{ffha_pkg::SIZE_W{1'b0}}, size_q};
    need_calc = (alloc_src[ffha_pkg::NEED_W-1:0] + ffha_pkg::NEED_W'(ffha_pkg::ALIGN - 1))
                & ~ffha_pkg::NEED_W'(ffha_pkg::ALIGN - 1);

    st.act        = act_q;
    st.ptr_zero   = (ptr_q == '0);
    st.size_zero  = (size_q == '0);
    st.alloc_bad  = (alloc_src == '0) || (alloc_src > 64'(ffha_pkg::HEAP_BYTES));
    st.calloc_ovf = (size_q != '0) && (prod > 64'(ffha_pkg::HEAP_BYTES));
    st.k_end      = (k == cnt);
    st.fit        = rd_q.free && ({1'b0, rd_q.size} >= need);
    st.split_ok   = (HDR_W'(rd_q.size) >=
                     HDR_W'(need) + HDR_W'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN))
                    && (cnt < ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS));
    st.match      = (HDR_W'(rd_q.start) + HDR_W'(ffha_pkg::HEADER_BYTES)) == HDR_W'(ptr_q);
    st.rd_free    = rd_q.free;
    st.j_at_split = (j == ffha_pkg::CNT_W'(fidx) + 1'b1);
    st.has_next   = (ffha_pkg::CNT_W'(fidx) + 1'b1) < cnt;
    st.j_lt_cnt   = (j < cnt);
    st.old_fits   = ffha_pkg::SIZE_W'(fent.size) >= size_q;

    // Neighbors to fold into the freed block; at most one on each side.
    nm       = st.has_next && rd_q.free;
    pm       = (fidx != '0) && pent.free;
    p_idx    = pm ? fidx - 1'b1 : fidx;
    rmv_calc = {1'b0, pm} + {1'b0, nm};
    cnt_less = cnt - ffha_pkg::CNT_W'(rmv_calc);
    merged.start = pm ? pent.start : fent.start;
    merged.size  = fent.size
                 + (nm ? rd_q.size + ffha_pkg::OFS_W'(ffha_pkg::HEADER_BYTES) : '0)
                 + (pm ? pent.size + ffha_pkg::OFS_W'(ffha_pkg::HEADER_BYTES) : '0);
    merged.free  = 1'b1;

    split_e.start = fent.start + ffha_pkg::OFS_W'(ffha_pkg::HEADER_BYTES)
                  + ffha_pkg::OFS_W'(need);
    split_e.size  = fent.size - ffha_pkg::OFS_W'(need)
                  - ffha_pkg::OFS_W'(ffha_pkg::HEADER_BYTES);
    split_e.free  = 1'b1;

    rd_en   = 1'b0;
    rd_addr = k[ffha_pkg::IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = fidx;
    wr_data = rd_q;
    case (cmd.op)
      ffha_pkg::OP_RD: begin
        rd_en = 1'b1;
      end
      ffha_pkg::OP_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = ffha_pkg::IDX_W'(j - 1'b1);
      end
      ffha_pkg::OP_RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = fidx + 1'b1;
      end
      ffha_pkg::OP_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = ffha_pkg::IDX_W'(j + ffha_pkg::CNT_W'(rmv));
      end
      ffha_pkg::OP_GRANT_WHOLE: begin
        wr_en   = 1'b1;
        wr_data = '{start: fent.start, size: fent.size, free: 1'b0};
      end
      ffha_pkg::OP_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = j[ffha_pkg::IDX_W-1:0];
      end
      ffha_pkg::OP_WR_NEW: begin
        wr_en   = 1'b1;
        wr_addr = fidx + 1'b1;
        wr_data = split_e;
      end
      ffha_pkg::OP_WR_OLD: begin
        wr_en   = 1'b1;
        wr_data = '{start: fent.start, size: ffha_pkg::OFS_W'(need), free: 1'b0};
      end
      ffha_pkg::OP_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = p_idx;
        wr_data = merged;
      end
      ffha_pkg::OP_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = j[ffha_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Block table storage; entry 0 reads as the whole free heap until written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= (rd_addr == '0 && init0) ? ffha_pkg::RESET_ENTRY : mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init0 <= 1'b1;
      cnt   <= ffha_pkg::CNT_W'(1);
      k     <= '0;
      j     <= '0;
      done  <= 1'b0;
    end else begin
      done <= (cmd.op == ffha_pkg::OP_EMIT);
      if (wr_en && wr_addr == '0) begin
        init0 <= 1'b0;
      end
      case (cmd.op)
        ffha_pkg::OP_LOAD, ffha_pkg::OP_KCLR: k <= '0;
        ffha_pkg::OP_NEXTK: k <= k + 1'b1;
        ffha_pkg::OP_FOUND: j <= cnt;
        ffha_pkg::OP_SH_WR: j <= j - 1'b1;
        ffha_pkg::OP_WR_OLD: cnt <= cnt + 1'b1;
        ffha_pkg::OP_MERGE: begin
          cnt <= cnt_less;
          j   <= (rmv_calc == '0) ? cnt_less : ffha_pkg::CNT_W'(p_idx) + 1'b1;
        end
        ffha_pkg::OP_UP_WR: j <= j + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ffha_pkg::OP_LOAD: begin
        act_q         <= ffha_pkg::action_t'(action);
        size_q        <= request_size;
        count_q       <= element_count;
        ptr_q         <= pointer_offset;
        result_offset <= '0;
        status        <= ffha_pkg::ST_DONE;
        copy_length   <= '0;
        zero_fill     <= 1'b0;
      end
      ffha_pkg::OP_MUL: prod <= count_q * size_q;
      ffha_pkg::OP_KCLR: need <= need_calc;
      ffha_pkg::OP_NEXTK: pent <= rd_q;
      ffha_pkg::OP_FOUND: begin
        fent <= rd_q;
        fidx <= k[ffha_pkg::IDX_W-1:0];
      end
      ffha_pkg::OP_GRANT_WHOLE, ffha_pkg::OP_WR_OLD: begin
        result_offset <= fent.start + ffha_pkg::OFS_W'(ffha_pkg::HEADER_BYTES);
        zero_fill     <= (act_q == ffha_pkg::ACT_CALLOC);
      end
      ffha_pkg::OP_MERGE: rmv <= rmv_calc;
      ffha_pkg::OP_SET_STATUS: status <= cmd.code;
      ffha_pkg::OP_RES_PTR: result_offset <= ptr_q;
      ffha_pkg::OP_SAVE_OLD: old_size <= fent.size;
      ffha_pkg::OP_RES_COPY: copy_length <= old_size;
      default: begin
      end
    endcase
  end

  `FFHA_ASSERT_IMP(a_cnt_range, 1'b1,
                   cnt != '0 && cnt <= ffha_pkg::CNT_W'(ffha_pkg::MAX_BLOCKS))
  `FFHA_ASSERT_NXT(a_split_grows, cmd.op == ffha_pkg::OP_WR_OLD,
                   cnt == $past(cnt) + 1'b1)
  `FFHA_ASSERT_NXT(a_done_pulse, done, !done)

endmodule

[rtl/ffha_ctrl.sv]
// Allocator controller: sequences scans, splits, merges and the result strobe.
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ffha_pkg::stat_t st,
  output ffha_pkg::cmd_t  cmd
);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_DISPATCH = 22'h000002,
    S_MUL      = 22'h000004,
    S_CHK      = 22'h000008,
    S_A_INIT   = 22'h000010,
    S_A_RD     = 22'h000020,
    S_A_EV     = 22'h000040,
    S_A_WHOLE  = 22'h000080,
    S_A_SH     = 22'h000100,
    S_A_SHW    = 22'h000200,
    S_A_NEW    = 22'h000400,
    S_A_OLD    = 22'h000800,
    S_A_OK     = 22'h001000,
    S_F_INIT   = 22'h002000,
    S_F_RD     = 22'h004000,
    S_F_EV     = 22'h008000,
    S_R_CHK    = 22'h010000,
    S_F_NXT    = 22'h020000,
    S_F_MRG    = 22'h040000,
    S_F_UP     = 22'h080000,
    S_F_UPW    = 22'h100000,
    S_EMIT     = 22'h200000
  } state_t;

  state_t state, state_next;
  logic   fmode, fmode_next;     // find is the size check of a resize
  logic   moving, moving_next;   // alloc is the move step of a resize

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    fmode_next  = fmode;
    moving_next = moving;
    cmd.op      = ffha_pkg::OP_NONE;
    cmd.code    = ffha_pkg::ST_DONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op      = ffha_pkg::OP_LOAD;
          moving_next = 1'b0;
          fmode_next  = 1'b0;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st.act)
          ffha_pkg::ACT_ALLOC: state_next = S_A_INIT;
          ffha_pkg::ACT_FREE: state_next = st.ptr_zero ? S_EMIT : S_F_INIT;
          ffha_pkg::ACT_REALLOC: begin
            if (st.ptr_zero) begin
              state_next = S_A_INIT;
            end else begin
              fmode_next = !st.size_zero;
              state_next = S_F_INIT;
            end
          end
          ffha_pkg::ACT_CALLOC: state_next = S_MUL;
          default: state_next = S_EMIT;
        endcase
      end
      S_MUL: begin
        cmd.op     = ffha_pkg::OP_MUL;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (st.calloc_ovf) begin
          cmd.op     = ffha_pkg::OP_SET_STATUS;
          cmd.code   = ffha_pkg::ST_FAIL;
          state_next = S_EMIT;
        end else begin
          state_next = S_A_INIT;
        end
      end
      S_A_INIT: begin
        if (st.alloc_bad) begin
          cmd.op     = ffha_pkg::OP_SET_STATUS;
          cmd.code   = ffha_pkg::ST_FAIL;
          state_next = S_EMIT;
        end else begin
          cmd.op     = ffha_pkg::OP_KCLR;
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        if (st.k_end) begin
          cmd.op     = ffha_pkg::OP_SET_STATUS;
          cmd.code   = ffha_pkg::ST_FAIL;
          state_next = S_EMIT;
        end else begin
          cmd.op     = ffha_pkg::OP_RD;
          state_next = S_A_EV;
        end
      end
      S_A_EV: begin
        if (st.fit) begin
          cmd.op     = ffha_pkg::OP_FOUND;
          state_next = st.split_ok ? S_A_SH : S_A_WHOLE;
        end else begin
          cmd.op     = ffha_pkg::OP_NEXTK;
          state_next = S_A_RD;
        end
      end
      S_A_WHOLE: begin
        cmd.op     = ffha_pkg::OP_GRANT_WHOLE;
        state_next = S_A_OK;
      end
      S_A_SH: begin
        if (st.j_at_split) begin
          state_next = S_A_NEW;
        end else begin
          cmd.op     = ffha_pkg::OP_SH_RD;
          state_next = S_A_SHW;
        end
      end
      S_A_SHW: begin
        cmd.op     = ffha_pkg::OP_SH_WR;
        state_next = S_A_SH;
      end
      S_A_NEW: begin
        cmd.op     = ffha_pkg::OP_WR_NEW;
        state_next = S_A_OLD;
      end
      S_A_OLD: begin
        cmd.op     = ffha_pkg::OP_WR_OLD;
        state_next = S_A_OK;
      end
      S_A_OK: begin
        if (moving) begin
          cmd.op     = ffha_pkg::OP_RES_COPY;
          fmode_next = 1'b0;
          state_next = S_F_INIT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_F_INIT: begin
        cmd.op     = ffha_pkg::OP_KCLR;
        state_next = S_F_RD;
      end
      S_F_RD: begin
        if (st.k_end) begin
          cmd.op     = ffha_pkg::OP_SET_STATUS;
          cmd.code   = ffha_pkg::ST_BADPTR;
          state_next = S_EMIT;
        end else begin
          cmd.op     = ffha_pkg::OP_RD;
          state_next = S_F_EV;
        end
      end
      S_F_EV: begin
        if (st.match && st.rd_free) begin
          cmd.op     = ffha_pkg::OP_SET_STATUS;
          cmd.code   = ffha_pkg::ST_DOUBLE;
          state_next = S_EMIT;
        end else if (st.match) begin
          cmd.op     = ffha_pkg::OP_FOUND;
          state_next = fmode ? S_R_CHK : S_F_NXT;
        end else begin
          cmd.op     = ffha_pkg::OP_NEXTK;
          state_next = S_F_RD;
        end
      end
      S_R_CHK: begin
        if (st.old_fits) begin
          cmd.op     = ffha_pkg::OP_RES_PTR;
          state_next = S_EMIT;
        end else begin
          cmd.op      = ffha_pkg::OP_SAVE_OLD;
          moving_next = 1'b1;
          fmode_next  = 1'b0;
          state_next  = S_A_INIT;
        end
      end
      S_F_NXT: begin
        if (st.has_next) begin
          cmd.op = ffha_pkg::OP_RD_NEXT;
        end
        state_next = S_F_MRG;
      end
      S_F_MRG: begin
        cmd.op     = ffha_pkg::OP_MERGE;
        state_next = S_F_UP;
      end
      S_F_UP: begin
        if (st.j_lt_cnt) begin
          cmd.op     = ffha_pkg::OP_UP_RD;
          state_next = S_F_UPW;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_F_UPW: begin
        cmd.op     = ffha_pkg::OP_UP_WR;
        state_next = S_F_UP;
      end
      S_EMIT: begin
        cmd.op     = ffha_pkg::OP_EMIT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fmode  <= 1'b0;
      moving <= 1'b0;
    end else begin
      state  <= state_next;
      fmode  <= fmode_next;
      moving <= moving_next;
    end
  end

endmodule

[rtl/first_fit_heap_allocator_unit.sv]
// Top level of the first-fit heap allocator with free-block coalescing.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// --------  ------------------------  ----------------------------------------------
// request   start, busy               action, request_size, element_count,
//                                     pointer_offset
// result    done (one-cycle strobe)   result_offset, status, copy_length, zero_fill
//
// A request is taken at a rising edge where start is high and busy is low.
// The block works on one request at a time. Every table access is a read
// followed by an evaluate or write step on the block table, so the time a request
// takes grows with the entries scanned and with the entries moved when a split
// opens a slot or a merge closes one; the longest case is a realloc that must
// move within a full 64-entry table.
// Reset is synchronous; afterwards the table holds one free block spanning the
// heap and no clearing pass is needed. The result strobe cannot be held off.

module first_fit_heap_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  action,
  input  logic [ffha_pkg::SIZE_W-1:0] request_size,
  input  logic [ffha_pkg::SIZE_W-1:0] element_count,
  input  logic [ffha_pkg::OFS_W-1:0]  pointer_offset,
  output logic                        done,
  output logic [ffha_pkg::OFS_W-1:0]  result_offset,
  output logic [1:0]                  status,
  output logic [ffha_pkg::OFS_W-1:0]  copy_length,
  output logic                        zero_fill
);

  // The controller issues one datapath command per cycle and branches on
  // the status flags that the datapath derives from its registers.
  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t st;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  ffha_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .action         (action),
    .request_size   (request_size),
    .element_count  (element_count),
    .pointer_offset (pointer_offset),
    .done           (done),
    .result_offset  (result_offset),
    .status         (status),
    .copy_length    (copy_length),
    .zero_fill      (zero_fill)
  );

endmodule
